// File: src/range_velocity_moving_average_macros.svh
// Assertion macros shared by the moving-average RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef RANGE_VELOCITY_MOVING_AVERAGE_MACROS_SVH
`define RANGE_VELOCITY_MOVING_AVERAGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rva_pkg.sv
// Package for the range/velocity moving-average filter: widths, register codes
// and the velocity scale table. No dependencies.
package rva_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    localparam int DIST_W  = 16;
    localparam int VRAW_W  = 8;
    localparam int VEL_W   = 15;
    localparam int DSUM_W  = 22;
    localparam int VSUM_W  = 21;
    localparam int DIV_W   = 22;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int MODE_W  = 4;
    localparam int SCALE_W = 8;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_DIST_WIN = 2'd0;
    localparam logic [1:0] REG_VEL_WIN  = 2'd1;
    localparam logic [1:0] REG_VEL_MODE = 2'd2;

    localparam logic [LEN_W-1:0]  WIN_RESET = LEN_W'(10);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_LEN);
    localparam logic [VEL_W-1:0]  DEADBAND  = VEL_W'(9);

    localparam logic [MODE_W-1:0] MODE_X25  = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_X50  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_X100 = MODE_W'(4);

    typedef logic [LEN_W-1:0] len_t;

    function automatic logic [SCALE_W-1:0] vel_scale(input logic [MODE_W-1:0] mode);
        logic [SCALE_W-1:0] s;
        case (mode)
            MODE_X25:  s = SCALE_W'(25);
            MODE_X50:  s = SCALE_W'(50);
            MODE_X100: s = SCALE_W'(100);
            default:   s = SCALE_W'(10);
        endcase
        return s;
    endfunction

    // Written window values are clamped to 1..MAX_LEN.
    function automatic len_t clamp_len(input logic [LEN_W-1:0] v);
        len_t r;
        if (v == '0)
            r = len_t'(1);
        else if (v > LEN_MAX)
            r = LEN_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: src/range_velocity_moving_average.sv
// Range/velocity moving-average filter with a velocity deadband and an APB register port.
// Depends on rva_pkg and range_velocity_moving_average_macros.svh.
//
//   channel   | dir | payload                                          | handshake
//   ----------+-----+--------------------------------------------------+-------------------
//   s_axis    | in  | tuser: kind; tdata: distance, velocity sample    | tvalid/tready
//   m_axis    | out | tdata: distance_avg, velocity_avg                | tvalid/tready
//   apb       | in  | 2 windows, velocity mode                         | psel/penable, pready=1
//
// Each item passes through a ring read, a sum update, 22 steps of the shared restoring
// divider by the window length, and a finish step; the block accepts a new item only once
// the last one has left the finish step. Results wait in an output register, so a stalled
// output holds only the finish step. Reset is asynchronous; a window change refills the
// ring at once through per-entry valid bits and a fill value.
`include "range_velocity_moving_average_macros.svh"

module range_velocity_moving_average (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] distance_sample, [23:16] velocity_sample
    input  logic [23:0]                  s_axis_tdata,
    // [0] kind
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] distance_avg, [30:16] velocity_avg, [31] zero
    output logic [31:0]                  m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rva_pkg::PADDR_W-1:0]  paddr,
    input  logic [rva_pkg::PDATA_W-1:0]  pwdata,
    output logic [rva_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import rva_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]                state_reg, state_next;

    len_t                      dist_win_reg, vel_win_reg;
    logic [MODE_W-1:0]         vel_mode_reg;

    logic [DIST_W-1:0]         dist_ring [MAX_LEN];
    logic signed [VEL_W-1:0]   vel_ring  [MAX_LEN];
    logic [MAX_LEN-1:0]        dist_valid_reg, vel_valid_reg;
    logic [DIST_W-1:0]         dist_fill_reg;
    logic signed [VEL_W-1:0]   vel_fill_reg;
    logic [DIST_W-1:0]         dist_rd_reg;
    logic signed [VEL_W-1:0]   vel_rd_reg;

    logic [DSUM_W-1:0]         dist_sum_reg;
    logic signed [VSUM_W-1:0]  vel_sum_reg;
    logic [IDX_W-1:0]          dist_idx_reg, vel_idx_reg;
    logic [DIST_W-1:0]         dist_out_reg;
    logic signed [VEL_W-1:0]   vel_out_reg;

    logic                      kind_reg;
    logic [DIST_W-1:0]         dist_smp_reg;
    logic signed [VRAW_W-1:0]  vel_smp_reg;
    logic signed [VEL_W-1:0]   scaled_reg;
    logic [IDX_W-1:0]          cur_idx_reg;
    len_t                      len_reg;

    logic [LEN_W:0]            rem_reg;
    logic [DIV_W-1:0]          quo_reg;
    logic [DCNT_W-1:0]         cnt_reg;
    logic                      neg_reg;

    logic                      m_valid_reg;
    logic [31:0]               m_data_reg;

    logic                      in_acc, cfg_wr, leave_fin;
    logic [1:0]                cfg_idx;
    logic [LEN_W-1:0]          wr_len;
    len_t                      sel_len, new_len;
    logic [IDX_W-1:0]          sel_idx, idx_inc;
    logic [DIST_W-1:0]         dist_old;
    logic signed [VEL_W-1:0]   vel_old;
    logic [DSUM_W-1:0]         dist_sum_new;
    logic signed [VSUM_W-1:0]  vel_sum_new;
    logic signed [DIV_W-1:0]   vel_num;
    logic [DIV_W-1:0]          div_num;
    logic [LEN_W:0]            rem_shift;
    logic                      rem_ge;
    logic [VEL_W-1:0]          vel_mag;
    logic signed [VEL_W-1:0]   vel_fin;
    logic [DIST_W-1:0]         dist_fin;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign cfg_idx       = paddr[3:2];
    assign wr_len        = pwdata[LEN_W-1:0];
    assign new_len       = clamp_len(wr_len);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign leave_fin     = (state_reg == ST_FIN) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_DIST_WIN: prdata = PDATA_W'(dist_win_reg);
            REG_VEL_WIN:  prdata = PDATA_W'(vel_win_reg);
            REG_VEL_MODE: prdata = PDATA_W'(vel_mode_reg);
            default:      prdata = '0;
        endcase
    end

    // Channel selection at acceptance; an out-of-range index restarts at zero.
    always_comb
    begin
        sel_len = s_axis_tuser ? vel_win_reg : dist_win_reg;
        sel_idx = s_axis_tuser ? vel_idx_reg : dist_idx_reg;
        if (LEN_W'(sel_idx) >= sel_len)
            sel_idx = '0;
    end

    // Sum update; entries not written since the last refill read as the fill value.
    always_comb
    begin
        dist_old     = dist_valid_reg[cur_idx_reg] ? dist_rd_reg : dist_fill_reg;
        vel_old      = vel_valid_reg[cur_idx_reg] ? vel_rd_reg : vel_fill_reg;
        dist_sum_new = dist_sum_reg - DSUM_W'(dist_old) + DSUM_W'(dist_smp_reg);
        vel_sum_new  = vel_sum_reg - VSUM_W'(vel_old) + VSUM_W'(scaled_reg);
        vel_num      = DIV_W'(vel_sum_new) + DIV_W'(len_reg >> 1);
        if (kind_reg)
            div_num = vel_num[DIV_W-1] ? DIV_W'(-vel_num) : DIV_W'(vel_num);
        else
            div_num = dist_sum_new + DIV_W'(len_reg >> 1);
        idx_inc = cur_idx_reg + IDX_W'(1);
        if (LEN_W'(cur_idx_reg) + LEN_W'(1) >= len_reg)
            idx_inc = '0;
    end

    // One restoring division step per cycle.
    always_comb
    begin
        rem_shift = {rem_reg[LEN_W-1:0], quo_reg[DIV_W-1]};
        rem_ge    = (rem_shift >= {1'b0, len_reg});
    end

    // Quotient conditioning: sign restore for velocity and the deadband around zero.
    always_comb
    begin
        dist_fin = quo_reg[DIST_W-1:0];
        vel_mag  = quo_reg[VEL_W-1:0];
        if (vel_mag < DEADBAND)
            vel_fin = '0;
        else if (neg_reg)
            vel_fin = -$signed(vel_mag);
        else
            vel_fin = $signed(vel_mag);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_READ;
            ST_READ: state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN:  if (leave_fin) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Ring memories: one registered read, one write per cycle each.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            dist_rd_reg <= dist_ring[cur_idx_reg];
        if (state_reg == ST_SUM && !kind_reg)
            dist_ring[cur_idx_reg] <= dist_smp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            vel_rd_reg <= vel_ring[cur_idx_reg];
        if (state_reg == ST_SUM && kind_reg)
            vel_ring[cur_idx_reg] <= scaled_reg;
    end

    // Item payload and divider datapath.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg     <= s_axis_tuser;
            dist_smp_reg <= s_axis_tdata[DIST_W-1:0];
            vel_smp_reg  <= $signed(s_axis_tdata[DIST_W +: VRAW_W]);
            cur_idx_reg  <= sel_idx;
            len_reg      <= sel_len;
        end
        if (state_reg == ST_READ)
            scaled_reg <= VEL_W'(vel_smp_reg * $signed({1'b0, vel_scale(vel_mode_reg)}));
        if (state_reg == ST_SUM)
        begin
            quo_reg <= div_num;
            rem_reg <= '0;
            cnt_reg <= DCNT_W'(DIV_W - 1);
            neg_reg <= kind_reg && vel_num[DIV_W-1];
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_ge ? (rem_shift - {1'b0, len_reg}) : rem_shift;
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
            cnt_reg <= cnt_reg - DCNT_W'(1);
        end
    end

    // Channel state, registers and refill on a window change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_win_reg   <= WIN_RESET;
            vel_win_reg    <= WIN_RESET;
            vel_mode_reg   <= '0;
            dist_valid_reg <= '0;
            vel_valid_reg  <= '0;
            dist_fill_reg  <= '0;
            vel_fill_reg   <= '0;
            dist_sum_reg   <= '0;
            vel_sum_reg    <= '0;
            dist_idx_reg   <= '0;
            vel_idx_reg    <= '0;
            dist_out_reg   <= '0;
            vel_out_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_DIST_WIN:
                    begin
                        if (wr_len != dist_win_reg)
                        begin
                            dist_win_reg   <= new_len;
                            dist_valid_reg <= '0;
                            dist_fill_reg  <= dist_out_reg;
                            dist_sum_reg   <= DSUM_W'(dist_out_reg * new_len);
                            dist_idx_reg   <= '0;
                        end
                    end
                    REG_VEL_WIN:
                    begin
                        if (wr_len != vel_win_reg)
                        begin
                            vel_win_reg   <= new_len;
                            vel_valid_reg <= '0;
                            vel_fill_reg  <= vel_out_reg;
                            vel_sum_reg   <= VSUM_W'(vel_out_reg * $signed({1'b0, new_len}));
                            vel_idx_reg   <= '0;
                        end
                    end
                    REG_VEL_MODE: vel_mode_reg <= pwdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_SUM)
            begin
                if (kind_reg)
                begin
                    vel_sum_reg                <= vel_sum_new;
                    vel_valid_reg[cur_idx_reg] <= 1'b1;
                    vel_idx_reg                <= idx_inc;
                end
                else
                begin
                    dist_sum_reg                <= dist_sum_new;
                    dist_valid_reg[cur_idx_reg] <= 1'b1;
                    dist_idx_reg                <= idx_inc;
                end
            end
            if (leave_fin)
            begin
                if (kind_reg)
                    vel_out_reg <= vel_fin;
                else
                    dist_out_reg <= dist_fin;
            end
        end
    end

    // Output register: the result of the finished item waits here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (leave_fin)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (leave_fin)
        begin
            if (kind_reg)
                m_data_reg <= {1'b0, vel_fin, dist_out_reg};
            else
                m_data_reg <= {1'b0, vel_out_reg, dist_fin};
        end
    end

    `RVA_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "accepted while busy")
    `RVA_ASSERT_NOW(a_dist_idx_in_window, 1'b1, LEN_W'(dist_idx_reg) < dist_win_reg, "distance index out of window")
    `RVA_ASSERT_NOW(a_vel_idx_in_window, 1'b1, LEN_W'(vel_idx_reg) < vel_win_reg, "velocity index out of window")
    `RVA_ASSERT_NOW(a_windows_legal, 1'b1, dist_win_reg != '0 && vel_win_reg != '0 && dist_win_reg <= LEN_MAX && vel_win_reg <= LEN_MAX, "window out of range")

endmodule
